// ===== hw/rtl/tstbe_pkg.sv =====
// Shared types and constants for the time-sorted table with size budget.
// No dependencies; imported by every module of the block.
package tstbe_pkg;

    localparam int SIZE_W        = 40;
    localparam int TIME_W        = 32;
    localparam int TOTAL_W       = 44;
    localparam int COUNT_OUT_W   = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [TOTAL_W-1:0] BUDGET_RESET = 44'd34359738368;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_ENFORCE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_INSERT = 2'd1;
    localparam cell_op_t OP_REMOVE = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [SIZE_W-1:0] entry_size;
        logic [TIME_W-1:0] entry_time;
    } req_t;

    typedef struct packed {
        logic                   status;
        logic                   evicted_valid;
        logic [SIZE_W-1:0]      evicted_size;
        logic [TIME_W-1:0]      evicted_time;
        logic [TOTAL_W-1:0]     total_size;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   new_ent;
    } cell_ctl_t;

    typedef struct packed {
        logic   valid;
        entry_t ent;
    } token_t;

endpackage

// ===== hw/rtl/tstbe_cell.sv =====
// One slot of the time-ordered table: holds an entry, takes part in the
// insert position chain and the minimum-size token chain. Uses tstbe_pkg.
module tstbe_cell
    import tstbe_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int CNT_W   = 5,
    parameter int IDX_W   = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] rm_idx,
    input  entry_t           left_ent,
    input  entry_t           right_ent,
    input  logic             keep_in,
    output logic             keep_out,
    input  token_t           tok_in,
    input  logic [IDX_W-1:0] tok_in_idx,
    output token_t           tok_out,
    output logic [IDX_W-1:0] tok_out_idx,
    output entry_t           ent
);

    entry_t           ent_reg;
    entry_t           ent_next;
    token_t           tok_reg;
    token_t           tok_next;
    logic [IDX_W-1:0] tok_idx_reg;
    logic [IDX_W-1:0] tok_idx_next;
    logic             occ;
    logic             before_new;
    logic             take_own;

    assign occ = CNT_W'(IDX) < count;

    // slot 0 stays ahead of the new entry on equal time, later slots only on smaller time
    always_comb
    begin
        if (IDX == 0)
        begin
            before_new = ent_reg.stamp <= ctl.new_ent.stamp;
        end
        else
        begin
            before_new = ent_reg.stamp < ctl.new_ent.stamp;
        end
    end

    assign keep_out = keep_in & occ & before_new;

    always_comb
    begin
        ent_next = ent_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (!keep_in)
                begin
                    ent_next = left_ent;
                end
                else if (!keep_out)
                begin
                    ent_next = ctl.new_ent;
                end
            end
            OP_REMOVE:
            begin
                if (IDX_W'(IDX) >= rm_idx)
                begin
                    ent_next = right_ent;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    // replace the passing candidate only on strictly smaller size
    assign take_own = occ & (!tok_in.valid | (ent_reg.size < tok_in.ent.size));

    always_comb
    begin
        if (take_own)
        begin
            tok_next.valid = 1'b1;
            tok_next.ent   = ent_reg;
            tok_idx_next   = IDX_W'(IDX);
        end
        else
        begin
            tok_next     = tok_in;
            tok_idx_next = tok_in_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            tok_idx_reg <= '0;
        end
        else
        begin
            tok_reg     <= tok_next;
            tok_idx_reg <= tok_idx_next;
        end
    end

    assign ent         = ent_reg;
    assign tok_out     = tok_reg;
    assign tok_out_idx = tok_idx_reg;

endmodule

// ===== hw/rtl/time_sorted_table_size_budget_evict.sv =====
// Top level: time-ordered table of (size, time) entries with budget eviction.
// Instantiates a row of tstbe_cell; uses tstbe_pkg.
//
// An insert request is taken while busy is low and its single result appears
// with done in the next cycle; busy does not rise, so a new request may follow
// at once. An enforce request with nothing to evict also answers in the next
// cycle. Otherwise each eviction runs a scan state, in which the minimum-size
// search passes a token one cell per cycle down the row of TABLE_DEPTH cells,
// then a remove state that closes the gap and issues the result. An enforce
// with k evictions holds busy until its last result is issued. Results are
// shown for one cycle only with done; the receiver cannot stall them. The user
// must write the budget with cfg_we while the block is idle, which is unenforced.
module time_sorted_table_size_budget_evict
    import tstbe_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               req,
    input  logic               cfg_we,
    input  logic [TOTAL_W-1:0] cfg_wdata,
    output logic               done,
    output result_t            result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] SCAN_LAST  = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_REMOVE = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [TOTAL_W-1:0] budget_reg;
    logic [TOTAL_W-1:0] budget_next;
    logic [IDX_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   scan_next;
    logic               done_reg;
    logic               done_next;
    result_t            result_reg;
    result_t            result_next;

    logic               accept;
    logic               full;
    logic [TOTAL_W-1:0] total_after_rm;
    cell_ctl_t          ctl;

    entry_t             ents   [TABLE_DEPTH];
    logic               keeps  [TABLE_DEPTH + 1];
    token_t             toks   [TABLE_DEPTH + 1];
    logic [IDX_W-1:0]   tidx   [TABLE_DEPTH + 1];

    assign keeps[0] = 1'b1;
    assign toks[0]  = '0;
    assign tidx[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            if (g == 0)
            begin : g_first
                assign left_e = '0;
            end
            else
            begin : g_mid_l
                assign left_e = ents[g - 1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_mid_r
                assign right_e = ents[g + 1];
            end
            tstbe_cell #(
                .IDX   (g),
                .CNT_W (CNT_W),
                .IDX_W (IDX_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .count       (count_reg),
                .rm_idx      (tidx[TABLE_DEPTH]),
                .left_ent    (left_e),
                .right_ent   (right_e),
                .keep_in     (keeps[g]),
                .keep_out    (keeps[g + 1]),
                .tok_in      (toks[g]),
                .tok_in_idx  (tidx[g]),
                .tok_out     (toks[g + 1]),
                .tok_out_idx (tidx[g + 1]),
                .ent         (ents[g])
            );
        end
    endgenerate

    assign accept         = start & (state_reg == ST_IDLE);
    assign full           = count_reg == COUNT_FULL;
    assign total_after_rm = total_reg - TOTAL_W'(toks[TABLE_DEPTH].ent.size);

    always_comb
    begin
        ctl.new_ent.size  = req.entry_size;
        ctl.new_ent.stamp = req.entry_time;
        ctl.op            = OP_HOLD;
        if (accept && (req.cmd == CMD_INSERT) && !full)
        begin
            ctl.op = OP_INSERT;
        end
        else if (state_reg == ST_REMOVE)
        begin
            ctl.op = OP_REMOVE;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        scan_next   = scan_reg;
        done_next   = 1'b0;
        budget_next = cfg_we ? cfg_wdata : budget_reg;

        result_next.status        = STATUS_OK;
        result_next.evicted_valid = 1'b0;
        result_next.evicted_size  = '0;
        result_next.evicted_time  = '0;
        result_next.total_size    = total_reg;
        result_next.entry_count   = COUNT_OUT_W'(count_reg);
        result_next.last          = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_INSERT)
                    begin
                        done_next = 1'b1;
                        if (full)
                        begin
                            result_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            total_next = total_reg + TOTAL_W'(req.entry_size);
                            result_next.total_size  = total_next;
                            result_next.entry_count = COUNT_OUT_W'(count_next);
                        end
                    end
                    else if ((total_reg > budget_reg) && (count_reg != '0))
                    begin
                        state_next = ST_SCAN;
                        scan_next  = '0;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SCAN_LAST)
                begin
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE:
            begin
                count_next = count_reg - 1'b1;
                total_next = total_after_rm;
                done_next  = 1'b1;
                result_next.evicted_valid = 1'b1;
                result_next.evicted_size  = toks[TABLE_DEPTH].ent.size;
                result_next.evicted_time  = toks[TABLE_DEPTH].ent.stamp;
                result_next.total_size    = total_next;
                result_next.entry_count   = COUNT_OUT_W'(count_next);
                result_next.last = !((total_after_rm > budget_reg) && (count_next != '0));
                scan_next  = '0;
                state_next = result_next.last ? ST_IDLE : ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            budget_reg <= BUDGET_RESET;
            scan_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            budget_reg <= budget_next;
            scan_reg   <= scan_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/tstbe_checker.sv =====
// Port-level checks for time_sorted_table_size_budget_evict, bound to the top.
// Uses tstbe_pkg.
module tstbe_checker
    import tstbe_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input req_t    req,
    input logic    done,
    input result_t result
);

    a_full_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == STATUS_FULL) |-> result.last && !result.evicted_valid)
        else $error("rejected insert must be a single final result");

    a_nonfinal_evicts: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |-> result.evicted_valid && (result.status == STATUS_OK))
        else $error("non-final result must report an eviction");

    a_insert_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.cmd == CMD_INSERT) |=> done && result.last)
        else $error("insert request not answered in the next cycle");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |=> busy && !done)
        else $error("block idle although further evictions are due");

endmodule

bind time_sorted_table_size_budget_evict tstbe_checker u_tstbe_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);
